>>> src/fse_pkg.sv
package fse_pkg;

  // Width of a data value and of the padded stream data bus.
  localparam int VALUE_W = 30;
  localparam int TDATA_W = 32;
  localparam int TUSER_IN_W  = 1;
  localparam int TUSER_OUT_W = 2;

  // Operation codes carried on the input tuser bit.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // Bit positions in the output tuser.
  localparam int TUSER_VALID_BIT    = 0;
  localparam int TUSER_OVERFLOW_BIT = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the input word into the datapath
    logic scan_step;  // advance the table scan by one slot
    logic inc;        // bump the count of the slot that matched
    logic append;     // add a new slot, or flag overflow when full
    logic take;       // claim the best slot found by the scan
    logic emit;       // load the output register
  } fse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_pull;    // the held word is a pull
    logic need_pick;  // no copies of the current slot remain
    logic match;      // the slot just read holds the pushed value
    logic scan_end;   // every occupied slot has been compared
    logic out_free;   // the output register can take a word
  } fse_sts_t;

endpackage

>>> src/fse_ram.sv
module fse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/fse_ctrl.sv
module fse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  fse_pkg::fse_sts_t sts,
  output fse_pkg::fse_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_PSCAN = 3'd2;
  localparam logic [2:0] ST_KSCAN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (!sts.op_pull) begin
          state_next = ST_PSCAN;
        end else if (sts.need_pick) begin
          state_next = ST_KSCAN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_PSCAN: begin
        if (sts.match) begin
          cmd.inc    = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.scan_end) begin
          cmd.append = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_KSCAN: begin
        if (sts.scan_end) begin
          cmd.take   = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/fse_datapath.sv
module fse_datapath #(
  parameter int DISTINCT_SLOTS = 256,
  parameter int MAX_COUNT      = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fse_pkg::fse_cmd_t                      cmd,
  output fse_pkg::fse_sts_t                      sts,
  input  logic                                   in_op,
  input  logic [fse_pkg::VALUE_W-1:0]            in_value,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [fse_pkg::VALUE_W-1:0]            out_value,
  output logic                                   out_valid_res,
  output logic                                   out_last,
  output logic                                   out_overflow
);

  localparam int SW = $clog2(DISTINCT_SLOTS);
  localparam int UW = $clog2(DISTINCT_SLOTS + 1);
  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int VW = fse_pkg::VALUE_W;
  localparam int EW = 1 + CW + VW;

  // Held input word.
  logic          op_q;
  logic [VW-1:0] val_q;

  // Set-level state.
  logic [UW-1:0] used;
  logic [CW-1:0] repeats;
  logic          draining;
  logic          overflow_flag;
  logic [VW-1:0] cur_val;
  logic          others;

  // Scan pipeline.
  logic [UW-1:0] scan_addr;
  logic          rd_vld;
  logic [SW-1:0] rd_idx;
  logic          issue;

  // Best candidate of a pick scan.
  logic [CW-1:0] best_cnt;
  logic [SW-1:0] best_idx;
  logic [VW-1:0] best_val;
  logic [1:0]    cand;

  // Slot table port.
  logic          we;
  logic [SW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;
  logic          rd_done;
  logic [CW-1:0] rd_cnt;
  logic [VW-1:0] rd_val;

  assign {rd_done, rd_cnt, rd_val} = rdata;
  assign issue = cmd.scan_step && (scan_addr < used);

  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = rdata;
    if (cmd.inc) begin
      we    = 1'b1;
      waddr = rd_idx;
      wdata = {rd_done, (rd_cnt < CW'(MAX_COUNT)) ? rd_cnt + CW'(1) : rd_cnt, rd_val};
    end else if (cmd.append) begin
      we    = (used < UW'(DISTINCT_SLOTS));
      waddr = used[SW-1:0];
      wdata = {1'b0, CW'(1), val_q};
    end else if (cmd.take) begin
      we    = (best_cnt != '0);
      waddr = best_idx;
      wdata = {1'b1, best_cnt, best_val};
    end
  end

  fse_ram #(
    .WIDTH(EW),
    .DEPTH(DISTINCT_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(scan_addr[SW-1:0]),
    .rdata(rdata)
  );

  assign sts.op_pull   = (op_q == fse_pkg::OP_PULL);
  assign sts.need_pick = (repeats == '0);
  assign sts.match     = rd_vld && (rd_val == val_q);
  assign sts.scan_end  = (scan_addr == used) && !rd_vld;
  assign sts.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= in_op;
      val_q    <= in_value;
      best_cnt <= '0;
      cand     <= '0;
    end else if (rd_vld && !rd_done) begin
      if (cand != 2'd2) begin
        cand <= cand + 2'd1;
      end
      if (rd_cnt > best_cnt) begin
        best_cnt <= rd_cnt;
        best_idx <= rd_idx;
        best_val <= rd_val;
      end
    end
    rd_idx <= scan_addr[SW-1:0];
    if (cmd.take) begin
      cur_val <= best_val;
      others  <= (cand == 2'd2);
    end
    if (cmd.emit) begin
      out_value     <= (repeats != '0) ? cur_val : '0;
      out_valid_res <= (repeats != '0);
      out_last      <= (repeats == CW'(1)) && !others;
      out_overflow  <= overflow_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      repeats       <= '0;
      draining      <= 1'b0;
      overflow_flag <= 1'b0;
      scan_addr     <= '0;
      rd_vld        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.load) begin
        scan_addr <= '0;
        if (in_op == fse_pkg::OP_PUSH && draining) begin
          used     <= '0;
          repeats  <= '0;
          draining <= 1'b0;
        end else if (in_op == fse_pkg::OP_PULL && !draining) begin
          repeats  <= '0;
          draining <= 1'b1;
        end
      end else if (issue) begin
        scan_addr <= scan_addr + UW'(1);
      end
      if (cmd.append) begin
        if (used < UW'(DISTINCT_SLOTS)) begin
          used <= used + UW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.take) begin
        repeats <= best_cnt;
      end
      if (cmd.emit && repeats != '0) begin
        repeats <= repeats - CW'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> src/frequency_sort_engine_top.sv
// Channel  Direction  Handshake          Payload
// s        in         s_tvalid s_tready  s_tdata value, s_tuser op (0 push, 1 pull)
// m        out        m_tvalid m_tready  m_tdata sorted value, m_tuser valid/overflow, m_tlast
//
// A push scans the occupied slots: the slot table is read one entry per cycle while the
// value is compared.
// A pull that opens a new value scans every occupied slot for the highest unemitted
// count; a pull that repeats the current value goes straight to the output register.
// Reset is synchronous and empties the table at once. The input is taken whenever the
// engine is idle, even while a word waits in the output register; a pull then stalls.
module frequency_sort_engine_top #(
  parameter int DISTINCT_SLOTS = 256,
  parameter int MAX_COUNT      = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata: [29:0] value, [31:30] zero
  input  logic [fse_pkg::TDATA_W-1:0]        s_tdata,
  // s_tuser: [0] op
  input  logic [fse_pkg::TUSER_IN_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata: [29:0] out_value, [31:30] zero
  output logic [fse_pkg::TDATA_W-1:0]        m_tdata,
  // m_tuser: [0] valid_res, [1] overflow
  output logic [fse_pkg::TUSER_OUT_W-1:0]    m_tuser,
  output logic                               m_tlast
);

  fse_pkg::fse_cmd_t cmd;
  fse_pkg::fse_sts_t sts;

  logic [fse_pkg::VALUE_W-1:0] out_value;
  logic                        out_valid_res;
  logic                        out_overflow;

  // The controller sequences each word through load, scan, update and emit.
  fse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the slot table, the set-level state and the output register.
  fse_datapath #(
    .DISTINCT_SLOTS(DISTINCT_SLOTS),
    .MAX_COUNT     (MAX_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (s_tuser[0]),
    .in_value     (s_tdata[fse_pkg::VALUE_W-1:0]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_value    (out_value),
    .out_valid_res(out_valid_res),
    .out_last     (m_tlast),
    .out_overflow (out_overflow)
  );

  assign m_tdata = {{(fse_pkg::TDATA_W - fse_pkg::VALUE_W){1'b0}}, out_value};
  assign m_tuser[fse_pkg::TUSER_VALID_BIT]    = out_valid_res;
  assign m_tuser[fse_pkg::TUSER_OVERFLOW_BIT] = out_overflow;

endmodule

>>> bench/testbench.sv
// Self-checking bench for the frequency sort engine. Push words load values
// into the slot table and pull words read them back in frequency order. A
// model kept inside this module predicts every pulled word as the pull is
// accepted, and a checker compares each word leaving the engine against the
// oldest prediction. Both stream sides idle at random, apart from stretches
// in which they run flat out.
module testbench;

  localparam int VW           = fse_pkg::VALUE_W;
  localparam int DW           = fse_pkg::TDATA_W;
  localparam int SLOTS        = 256;   // distinct values the table can hold
  localparam int COUNT_CAP    = 1024;  // a count stops rising here
  localparam int RANDOM_WORDS = 300;   // size of the random part
  localparam int STALL_LIMIT  = 5000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 300;   // outlasts a push into a full table

  // One word as it should leave the engine.
  typedef struct packed {
    logic [VW-1:0] value;
    logic          valid;
    logic          last;
    logic          overflow;
  } sorted_word_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   s_tvalid = 1'b0;
  logic                                   s_tready;
  logic [DW-1:0]                          s_tdata = '0;
  logic [fse_pkg::TUSER_IN_W-1:0]         s_tuser = '0;
  logic                                   m_tvalid;
  logic                                   m_tready = 1'b0;
  logic [DW-1:0]                          m_tdata;
  logic [fse_pkg::TUSER_OUT_W-1:0]        m_tuser;
  logic                                   m_tlast;

  // Predicted words, oldest first, and the bookkeeping of the run.
  sorted_word_t pending_words[$];
  int           errors = 0;
  int           words_sent = 0;
  bit           steady = 1'b0;  // when set, neither side idles

  // Own copy of the engine's slot table and drain state.
  logic [VW-1:0] tbl_value   [SLOTS];
  logic [10:0]   tbl_count   [SLOTS];
  bit            tbl_emitted [SLOTS];
  int            tbl_used      = 0;
  int            run_slot      = 0;
  int            run_left      = 0;
  bit            draining_now  = 1'b0;
  bit            overflow_seen = 1'b0;

  frequency_sort_engine_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // A push opens a fresh data set if pulling had begun, then either bumps
  // the count of a known value or claims the next slot. With every slot
  // taken, a new value is lost and the sticky overflow flag goes up.
  function automatic void count_push(logic [VW-1:0] v);
    int i;
    if (draining_now) begin
      tbl_used     = 0;
      run_slot     = 0;
      run_left     = 0;
      draining_now = 1'b0;
    end
    for (i = 0; i < tbl_used; i++) begin
      if (tbl_value[i] == v) begin
        if (tbl_count[i] < COUNT_CAP) tbl_count[i]++;
        return;
      end
    end
    if (tbl_used < SLOTS) begin
      tbl_value[tbl_used]   = v;
      tbl_count[tbl_used]   = 11'd1;
      tbl_emitted[tbl_used] = 1'b0;
      tbl_used++;
    end else begin
      overflow_seen = 1'b1;
    end
  endfunction

  // Highest count not yet emitted; the strict comparison keeps the earliest
  // slot on a tie. SLOTS means nothing is left.
  function automatic int best_unemitted();
    int i;
    int best;
    int best_cnt;
    best     = SLOTS;
    best_cnt = 0;
    for (i = 0; i < tbl_used; i++) begin
      if (!tbl_emitted[i] && int'(tbl_count[i]) > best_cnt) begin
        best_cnt = int'(tbl_count[i]);
        best     = i;
      end
    end
    return best;
  endfunction

  // The word a pull should return, advancing the drain state.
  function automatic sorted_word_t next_sorted_word();
    sorted_word_t w;
    int           s;
    w = '0;
    if (!draining_now) begin
      draining_now = 1'b1;
      run_left     = 0;
    end
    if (run_left == 0) begin
      s = best_unemitted();
      if (s < SLOTS) begin
        tbl_emitted[s] = 1'b1;
        run_slot       = s;
        run_left       = int'(tbl_count[s]);
      end
    end
    if (run_left != 0) begin
      w.valid = 1'b1;
      w.value = tbl_value[run_slot];
      run_left--;
      w.last  = (run_left == 0) && (best_unemitted() >= SLOTS);
    end
    w.overflow = overflow_seen;
    return w;
  endfunction

  // Valid words still to come from the current set.
  function automatic int words_left();
    int i;
    int n;
    n = run_left;
    for (i = 0; i < tbl_used; i++) begin
      if (!tbl_emitted[i]) n += int'(tbl_count[i]);
    end
    return n;
  endfunction

  function automatic logic [VW-1:0] random_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $time, field, got, want);
    errors++;
  endtask

  // Offers one word and waits for the engine to take it. The valid stays
  // high afterwards, so back-to-back words need no gap; the prediction is
  // made at the very edge on which the word is accepted.
  task automatic send_word(input logic op, input logic [VW-1:0] val);
    while (!steady && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(DW-VW){1'b0}}, val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == fse_pkg::OP_PULL) pending_words.insert(pending_words.size(), next_sorted_word());
    else count_push(val);
    words_sent++;
  endtask

  task automatic send_pulls(input int n);
    repeat (n) send_word(fse_pkg::OP_PULL, random_value());
  endtask

  // Holds the input back until every predicted word has been seen. It waits
  // for a clock edge first, so a following word never raises the valid in
  // the same step in which it was lowered here.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // A pull puts the engine into draining, so the next push opens a new set.
  task automatic start_fresh();
    if (!draining_now) send_word(fse_pkg::OP_PULL, '0);
  endtask

  // Pull on an empty table, value extremes, repeats, a tie broken by first
  // appearance, pulls past the end, and a push that cuts a drain short.
  task automatic test_directed_sorting();
    send_word(fse_pkg::OP_PULL, 30'h2AAAAAAA);
    send_word(fse_pkg::OP_PUSH, 30'h3FFFFFFF);
    send_word(fse_pkg::OP_PUSH, 30'h00000000);
    send_word(fse_pkg::OP_PUSH, 30'h15555555);
    send_word(fse_pkg::OP_PUSH, 30'h00000000);
    send_word(fse_pkg::OP_PUSH, 30'h2AAAAAAA);
    send_word(fse_pkg::OP_PUSH, 30'h3FFFFFFF);
    send_word(fse_pkg::OP_PUSH, 30'h00000000);
    send_pulls(9);
    send_word(fse_pkg::OP_PUSH, 30'h0000ABCD);
    send_word(fse_pkg::OP_PUSH, 30'h1234FEDC);
    send_word(fse_pkg::OP_PUSH, 30'h0000ABCD);
    send_pulls(1);
    send_word(fse_pkg::OP_PUSH, 30'h3FFF0001);
    send_pulls(2);
    wait_drained();
  endtask

  // Mostly whole sets: pushes drawn from a small pool so that counts repeat
  // and tie, then a drain that reaches the end, runs past it or stops early. Now and then
  // a larger set, and short bursts of words with random operations.
  task automatic test_random_sets();
    logic [VW-1:0] pool [128];
    int            first;
    int            pool_n;
    int            n;
    int            k;
    int            style;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      steady = (words_sent - first > 100) && (words_sent - first < 250);
      style  = $urandom_range(19);
      if (style >= 17) begin
        repeat ($urandom_range(1, 8)) send_word(1'($urandom_range(1)), random_value());
        continue;
      end
      if (style == 16) begin
        pool_n = $urandom_range(40, 120);
        n      = $urandom_range(pool_n, 150);
      end else begin
        pool_n = $urandom_range(1, 12);
        n      = $urandom_range(1, 30);
      end
      for (k = 0; k < pool_n; k++) pool[k] = random_value();
      repeat (n) send_word(fse_pkg::OP_PUSH, pool[$urandom_range(pool_n - 1)]);
      k = words_left();
      if ($urandom_range(3) == 0 && k > 1) k = $urandom_range(1, k - 1);
      else k += $urandom_range(0, 2);
      send_pulls(k);
      if ($urandom_range(9) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  // One value pushed well past the count ceiling must come out exactly as
  // many times as the ceiling allows, ahead of a rarer value.
  task automatic test_count_saturation();
    start_fresh();
    steady = 1'b1;
    repeat (COUNT_CAP + 6) send_word(fse_pkg::OP_PUSH, 30'h3FFFFFFF);
    repeat (2) send_word(fse_pkg::OP_PUSH, 30'h12345678);
    send_pulls(words_left() + 1);
    steady = 1'b0;
    wait_drained();
  endtask

  // Fill every slot, bump a known value, then offer one value too many. The
  // flag must show on every later word, across a new set as well.
  task automatic test_table_overflow();
    logic [VW-1:0] filled [SLOTS];
    int            i;
    start_fresh();
    for (i = 0; i < SLOTS; i++) begin
      filled[i] = {i[7:0], 22'($urandom)};
      send_word(fse_pkg::OP_PUSH, filled[i]);
    end
    send_word(fse_pkg::OP_PUSH, filled[5]);
    send_word(fse_pkg::OP_PUSH, filled[0] ^ 30'h1);
    send_pulls(3);
    send_word(fse_pkg::OP_PUSH, 30'h0F0F0F0F);
    send_word(fse_pkg::OP_PUSH, 30'h30303030);
    send_pulls(3);
  endtask

  // Every word leaving the engine is held against the oldest prediction.
  // The ready is then redrawn for the next edge.
  always @(posedge clk) begin : result_check
    sorted_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, '0);
      end else begin
        want = pending_words.pop_front();
        if (m_tdata[VW-1:0] !== want.value)
          report_mismatch("out_value", 32'(m_tdata[VW-1:0]), 32'(want.value));
        if (m_tuser[fse_pkg::TUSER_VALID_BIT] !== want.valid)
          report_mismatch("valid_res", 32'(m_tuser[fse_pkg::TUSER_VALID_BIT]),
                          32'(want.valid));
        if (m_tlast !== want.last)
          report_mismatch("last", 32'(m_tlast), 32'(want.last));
        if (m_tuser[fse_pkg::TUSER_OVERFLOW_BIT] !== want.overflow)
          report_mismatch("overflow", 32'(m_tuser[fse_pkg::TUSER_OVERFLOW_BIT]),
                          32'(want.overflow));
      end
    end
    m_tready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 20);
  end

  // Ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_sorting();
    test_random_sets();
    test_count_saturation();
    test_table_overflow();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
